>>> src/hrpi_pkg.sv
// Shared types and constants for the peak-interval heart rate block.
// Used by the interfaces, the serial divider, the serial blend unit and the top level.
package hrpi_pkg;

	localparam int COUNT_BITS_DEF = 16;

	localparam int SAMPLE_W   = 32;
	localparam int IVAL_W     = 16;
	localparam int NUM_W      = 16;
	localparam int ALPHA_W    = 9;
	localparam int RATE_W     = 18;
	localparam int BPM_W      = 11;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// numerator * 256 needs eight fraction bits below the numerator
	localparam int FRAC_W     = 8;
	localparam int DIVIDEND_W = NUM_W + FRAC_W;

	localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST = 32'sd1000000;
	localparam logic [IVAL_W-1:0]  MIN_INTERVAL_RST   = 16'd75;
	localparam logic [IVAL_W-1:0]  MAX_INTERVAL_RST   = 16'd500;
	localparam logic [NUM_W-1:0]   RATE_NUMERATOR_RST = 16'd15000;
	localparam logic [ALPHA_W-1:0] ALPHA_RST          = 9'd51;

	// full weight, 256/256
	localparam logic [ALPHA_W-1:0] WEIGHT_ONE = 9'd256;
	localparam logic [RATE_W-1:0]  RATE_MAX   = {RATE_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD      = 3'd0,
		REG_MIN_INTERVAL   = 3'd1,
		REG_MAX_INTERVAL   = 3'd2,
		REG_RATE_NUMERATOR = 3'd3,
		REG_ALPHA          = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MAC,
		ST_DONE
	} hrpi_state_t;

endpackage

>>> src/hrpi_if.sv
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on hrpi_pkg for field widths.
interface hrpi_sample_if;
	logic valid;
	logic ready;
	logic signed [hrpi_pkg::SAMPLE_W-1:0] energy;

	modport source (output valid, output energy, input ready);
	modport sink (input valid, input energy, output ready);
endinterface

interface hrpi_result_if;
	logic valid;
	logic ready;
	logic [hrpi_pkg::BPM_W-1:0] bpm;
	logic crossing;
	logic rate_updated;

	modport source (output valid, output bpm, output crossing, output rate_updated, input ready);
	modport sink (input valid, input bpm, input crossing, input rate_updated, output ready);
endinterface

interface hrpi_cfg_if;
	logic valid;
	logic ready;
	logic [hrpi_pkg::CFG_IDX_W-1:0] index;
	logic [hrpi_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/hrpi_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, saturated to the rate width.
// Depends on hrpi_pkg for widths.
module hrpi_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [hrpi_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [hrpi_pkg::IVAL_W-1:0] divisor,
	output logic done,
	output logic [hrpi_pkg::RATE_W-1:0] quotient
);

	localparam int DW   = hrpi_pkg::DIVIDEND_W;
	localparam int VW   = hrpi_pkg::IVAL_W;
	localparam int RW   = hrpi_pkg::RATE_W;
	localparam int CNTW = $clog2(DW);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [VW-1:0]   rem_q;
	logic [DW-1:0]   quo_q;
	logic [VW-1:0]   dvs_q;
	logic [VW:0]     trial;
	logic [VW:0]     diff;
	logic            qbit;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// dividend bits shift out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = (quo_q[DW-1:RW] != '0) ? hrpi_pkg::RATE_MAX : quo_q[RW-1:0];

endmodule

>>> src/hrpi_mac.sv
// Bit-serial shift-add blend: (w*new + (256-w)*old + 128) >> 8, one weight bit per cycle.
// Depends on hrpi_pkg for widths.
module hrpi_mac (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [hrpi_pkg::RATE_W-1:0] rate_new,
	input  logic [hrpi_pkg::RATE_W-1:0] rate_old,
	input  logic [hrpi_pkg::ALPHA_W-1:0] weight,
	output logic done,
	output logic [hrpi_pkg::RATE_W-1:0] result
);

	localparam int RW   = hrpi_pkg::RATE_W;
	localparam int WW   = hrpi_pkg::ALPHA_W;
	localparam int FW   = hrpi_pkg::FRAC_W;
	localparam int MW   = RW + WW - 1;
	localparam int AW   = MW + 1;
	localparam int CNTW = $clog2(WW);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [MW-1:0]   ma_q;
	logic [MW-1:0]   mb_q;
	logic [WW-1:0]   wa_q;
	logic [WW-1:0]   wb_q;
	logic [AW-1:0]   acc_q;
	logic [AW-1:0]   term_a;
	logic [AW-1:0]   term_b;

	assign term_a = wa_q[0] ? AW'(ma_q) : '0;
	assign term_b = wb_q[0] ? AW'(mb_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(WW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= MW'(rate_new);
			mb_q  <= MW'(rate_old);
			wa_q  <= weight;
			wb_q  <= hrpi_pkg::WEIGHT_ONE - weight;
			// rounding half
			acc_q <= AW'(1) << (FW - 1);
		end else if (busy_q) begin
			acc_q <= acc_q + term_a + term_b;
			ma_q  <= {ma_q[MW-2:0], 1'b0};
			mb_q  <= {mb_q[MW-2:0], 1'b0};
			wa_q  <= {1'b0, wa_q[WW-1:1]};
			wb_q  <= {1'b0, wb_q[WW-1:1]};
		end
	end

	assign done   = done_q;
	assign result = acc_q[FW +: RW];

endmodule

>>> src/heart_rate_from_peak_interval.sv
// Top level: registers, threshold crossing and interval tracking, sequencer, result register.
// Depends on hrpi_pkg, hrpi_if, hrpi_div and hrpi_mac.
//
//  channel   role  payload
//  samples   sink  energy
//  results   src   bpm, crossing, rate_updated
//  cfg       sink  index, data (always ready)
//
// A sample without an accepted interval passes the accept edge, then the result register
// load. A sample that updates the rate passes the accept edge, 24 steps of the restoring
// divider, a hand-over, 9 steps of the shift-add blend, the commit of the rate and the
// result register load.
// No clearing pass: samples are taken from the first edge after reset.
// A stalled results channel holds the finished item in the sequencer until the register frees.
module heart_rate_from_peak_interval #(
	parameter int COUNT_BITS = hrpi_pkg::COUNT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	hrpi_sample_if.sink samples,
	hrpi_result_if.source results,
	hrpi_cfg_if.sink cfg
);

	localparam int CMPW = (COUNT_BITS > hrpi_pkg::IVAL_W) ? COUNT_BITS : hrpi_pkg::IVAL_W;
	localparam int RW   = hrpi_pkg::RATE_W;
	localparam int BW   = hrpi_pkg::BPM_W;
	localparam int FW   = hrpi_pkg::FRAC_W;

	logic signed [hrpi_pkg::SAMPLE_W-1:0] thr_q;
	logic [hrpi_pkg::IVAL_W-1:0]  min_q;
	logic [hrpi_pkg::IVAL_W-1:0]  max_q;
	logic [hrpi_pkg::NUM_W-1:0]   num_q;
	logic [hrpi_pkg::ALPHA_W-1:0] alpha_q;

	logic [COUNT_BITS-1:0] since_q;
	logic                  have_q;
	logic                  above_q;
	logic [RW-1:0]         smooth_q;
	logic                  rvalid_q;
	logic [BW-1:0]         held_q;
	logic                  cross_q;
	logic                  upd_q;

	logic          ovalid_q;
	logic [BW-1:0] obpm_q;
	logic          ocross_q;
	logic          oupd_q;

	hrpi_pkg::hrpi_state_t state_q, state_d;

	logic                  accept;
	logic                  above;
	logic                  rise;
	logic [COUNT_BITS-1:0] since_inc;
	logic [CMPW-1:0]       ivx;
	logic                  iv_ok;
	logic                  div_start;
	logic                  div_done;
	logic [RW-1:0]         div_quo;
	logic                  mac_start;
	logic                  mac_done;
	logic [RW-1:0]         mac_res;
	logic [hrpi_pkg::ALPHA_W-1:0] weight;
	logic [RW:0]           round_sum;
	logic                  out_load;

	// sample path
	assign above     = samples.energy > thr_q;
	assign rise      = above && !above_q;
	assign since_inc = (since_q == {COUNT_BITS{1'b1}}) ? since_q
	                                                   : COUNT_BITS'(since_q + 1'b1);
	assign ivx       = CMPW'(since_inc);
	assign iv_ok     = rise && have_q && (ivx > CMPW'(min_q)) && (ivx < CMPW'(max_q));

	// first rate loads at full weight
	assign weight = (!rvalid_q || alpha_q > hrpi_pkg::WEIGHT_ONE) ? hrpi_pkg::WEIGHT_ONE
	                                                              : alpha_q;

	assign round_sum = {1'b0, mac_res} + (RW + 1)'(1 << (FW - 1));

	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		accept        = 1'b0;
		div_start     = 1'b0;
		mac_start     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			hrpi_pkg::ST_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					accept = 1'b1;
					if (iv_ok) begin
						div_start = 1'b1;
						state_d   = hrpi_pkg::ST_DIV;
					end else begin
						state_d = hrpi_pkg::ST_DONE;
					end
				end
			end
			hrpi_pkg::ST_DIV: begin
				if (div_done) begin
					mac_start = 1'b1;
					state_d   = hrpi_pkg::ST_MAC;
				end
			end
			hrpi_pkg::ST_MAC: begin
				if (mac_done) begin
					state_d = hrpi_pkg::ST_DONE;
				end
			end
			hrpi_pkg::ST_DONE: begin
				if (!ovalid_q || results.ready) begin
					out_load = 1'b1;
					state_d  = hrpi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hrpi_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrpi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= hrpi_pkg::THRESHOLD_RST;
			min_q   <= hrpi_pkg::MIN_INTERVAL_RST;
			max_q   <= hrpi_pkg::MAX_INTERVAL_RST;
			num_q   <= hrpi_pkg::RATE_NUMERATOR_RST;
			alpha_q <= hrpi_pkg::ALPHA_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				hrpi_pkg::REG_THRESHOLD:      thr_q   <= cfg.data;
				hrpi_pkg::REG_MIN_INTERVAL:   min_q   <= cfg.data[hrpi_pkg::IVAL_W-1:0];
				hrpi_pkg::REG_MAX_INTERVAL:   max_q   <= cfg.data[hrpi_pkg::IVAL_W-1:0];
				hrpi_pkg::REG_RATE_NUMERATOR: num_q   <= cfg.data[hrpi_pkg::NUM_W-1:0];
				hrpi_pkg::REG_ALPHA:          alpha_q <= cfg.data[hrpi_pkg::ALPHA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// beat tracking and smoothed rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_q  <= '0;
			have_q   <= 1'b0;
			above_q  <= 1'b0;
			smooth_q <= '0;
			rvalid_q <= 1'b0;
			held_q   <= '0;
			cross_q  <= 1'b0;
			upd_q    <= 1'b0;
		end else begin
			if (accept) begin
				above_q <= above;
				cross_q <= rise;
				upd_q   <= iv_ok;
				if (rise) begin
					since_q <= '0;
					have_q  <= 1'b1;
				end else begin
					since_q <= since_inc;
				end
			end
			if (mac_done) begin
				smooth_q <= mac_res;
				rvalid_q <= 1'b1;
				held_q   <= round_sum[RW:FW];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (results.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			obpm_q   <= held_q;
			ocross_q <= cross_q;
			oupd_q   <= upd_q;
		end
	end

	assign results.valid        = ovalid_q;
	assign results.bpm          = obpm_q;
	assign results.crossing     = ocross_q;
	assign results.rate_updated = oupd_q;

	hrpi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({num_q, FW'(0)}),
		.divisor  (ivx[hrpi_pkg::IVAL_W-1:0]),
		.done     (div_done),
		.quotient (div_quo)
	);

	hrpi_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mac_start),
		.rate_new (div_quo),
		.rate_old (smooth_q),
		.weight   (weight),
		.done     (mac_done),
		.result   (mac_res)
	);

`ifndef SYNTHESIS
	a_upd_has_cross: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (!results.rate_updated || results.crossing))
		else $error("rate update without a crossing");

	a_mac_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> state_q == hrpi_pkg::ST_MAC)
		else $error("blend finished outside its state");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == hrpi_pkg::ST_DIV)
		else $error("divide finished outside its state");

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= 11'd1024)
		else $error("held rate out of range");
`endif

endmodule
